/* rtl/sha256_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Shared types, round constants and the round and schedule helper functions.
// ----------------------------------------------------------------------------
package sha256_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_message;
	} sha_in_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_number;
		logic        final_word;
	} sha_out_t;

	localparam int BlockWords = 16;
	localparam int HashWords  = 8;
	localparam int Rounds     = 64;
	localparam logic [5:0] LenPos = 6'd56;
	localparam logic [31:0] PadMarker = 32'h80;

	localparam logic [31:0] IV [HashWords] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RC [Rounds] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] v);
		return rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] v);
		return rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] v);
		return rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] v);
		return rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
	endfunction

endpackage
`default_nettype wire

/* rtl/sha256_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sha256_ram #(
	parameter int Width = 32,
	parameter int Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

/* rtl/sha256_message_hasher_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// Byte-serial SHA-256 with padding and an eight-word digest output.
// ----------------------------------------------------------------------------
// Each item takes one message byte, an end mark, or both. A byte is written
// into the block memory as it is taken, so bytes are taken back to back until
// the 64th byte of a block. That byte starts a compression with the input
// held off: the block is copied into a 16-word schedule memory, 64 rounds
// run at one per cycle while the schedule is read and rewritten, and an add
// step adds the working words into the hash. The end of a message adds
// padding (up to 16 writes), the two length words (after a 14-word clear
// when a second block is needed), one or two compressions and eight output
// items; the input is stalled until the last digest word has been taken.
module sha256_message_hasher_top (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire sha256_pkg::sha_in_t  in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output sha256_pkg::sha_out_t      out_data
);
	import sha256_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_PAD, ST_LOAD, ST_ROUND, ST_ADD, ST_CLEAR, ST_LEN, ST_OUT
	} state_t;

	state_t      state_q;
	logic [31:0] hash_q [HashWords];
	logic [31:0] wk_q [HashWords];
	logic [63:0] bit_count_q;
	logic [5:0]  fill_q;
	logic [31:0] partial_q;
	logic [6:0]  cnt_q;
	logic        second_q;
	logic        final_q;
	logic        two_q;

	logic        blk_we;
	logic [3:0]  blk_waddr;
	logic [31:0] blk_wdata;
	logic [3:0]  blk_raddr;
	logic [31:0] blk_rdata;

	logic        w_we;
	logic [3:0]  w_waddr;
	logic [31:0] w_wdata;
	logic [3:0]  w_raddr0, w_raddr1, w_raddr2, w_raddr3;
	logic [31:0] w_rd0, w_rd1, w_rd2, w_rd3;

	sha256_ram #(.Width(32), .Depth(BlockWords)) u_blk (
		.clk(clk), .we(blk_we), .waddr(blk_waddr), .wdata(blk_wdata),
		.raddr(blk_raddr), .rdata(blk_rdata)
	);

	// Four copies of the schedule memory give the four reads of a round.
	sha256_ram #(.Width(32), .Depth(BlockWords)) u_w0 (
		.clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
		.raddr(w_raddr0), .rdata(w_rd0)
	);
	sha256_ram #(.Width(32), .Depth(BlockWords)) u_w1 (
		.clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
		.raddr(w_raddr1), .rdata(w_rd1)
	);
	sha256_ram #(.Width(32), .Depth(BlockWords)) u_w2 (
		.clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
		.raddr(w_raddr2), .rdata(w_rd2)
	);
	sha256_ram #(.Width(32), .Depth(BlockWords)) u_w3 (
		.clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
		.raddr(w_raddr3), .rdata(w_rd3)
	);

	logic        in_fire, out_fire;
	logic [1:0]  lane;
	logic [31:0] byte_word;
	logic [31:0] pad_word;
	logic [5:0]  rnd;
	logic [31:0] sched_w, t1, t2;
	logic [3:0]  lcnt;
	logic [5:0]  rnd_next;
	logic [31:0] wk_rd;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign lane     = fill_q[1:0];
	assign rnd      = cnt_q[5:0];
	assign lcnt     = cnt_q[3:0];
	assign rnd_next = rnd + 6'd1;

	always_comb begin
		case (lane)
			2'd0:    byte_word = {in_data.data_byte, 24'd0};
			2'd1:    byte_word = {partial_q[31:24], in_data.data_byte, 16'd0};
			2'd2:    byte_word = {partial_q[31:16], in_data.data_byte, 8'd0};
			default: byte_word = {partial_q[31:8], in_data.data_byte};
		endcase
		case (lane)
			2'd0:    pad_word = PadMarker << 24;
			2'd1:    pad_word = {partial_q[31:24], 24'd0} | (PadMarker << 16);
			2'd2:    pad_word = {partial_q[31:16], 16'd0} | (PadMarker << 8);
			default: pad_word = {partial_q[31:8], 8'd0} | PadMarker;
		endcase
	end

	// Each round sets the schedule read addresses of the next round, as read data is registered.
	assign sched_w = (rnd < 6'd16) ? w_rd0
		: (w_rd0 + ssig0(w_rd1) + w_rd2 + ssig1(w_rd3));
	assign wk_rd = sched_w;
	assign t1 = wk_q[7] + bsig1(wk_q[4]) + ((wk_q[4] & wk_q[5]) ^ (~wk_q[4] & wk_q[6]))
		+ RC[rnd] + wk_rd;
	assign t2 = bsig0(wk_q[0])
		+ ((wk_q[0] & wk_q[1]) ^ (wk_q[0] & wk_q[2]) ^ (wk_q[1] & wk_q[2]));

	always_comb begin
		blk_we    = 1'b0;
		blk_waddr = fill_q[5:2];
		blk_wdata = byte_word;
		blk_raddr = lcnt;
		w_we      = 1'b0;
		w_waddr   = lcnt;
		w_wdata   = blk_rdata;
		w_raddr0  = 4'd0;
		w_raddr1  = 4'd1;
		w_raddr2  = 4'd9;
		w_raddr3  = 4'd14;
		case (state_q)
			ST_IDLE: begin
				blk_we = in_fire && in_data.byte_present;
			end
			ST_PAD: begin
				blk_we    = 1'b1;
				blk_waddr = cnt_q[3:0];
				blk_wdata = (cnt_q[3:0] == fill_q[5:2]) ? pad_word : 32'd0;
			end
			ST_CLEAR: begin
				blk_we    = 1'b1;
				blk_waddr = lcnt;
				blk_wdata = 32'd0;
			end
			ST_LEN: begin
				blk_we    = 1'b1;
				blk_waddr = lcnt;
				blk_wdata = (lcnt == 4'd14) ? bit_count_q[63:32] : bit_count_q[31:0];
			end
			ST_LOAD: begin
				// Copy block into schedule memory; read data is registered, so each word is written to the previous read address.
				blk_raddr = lcnt;
				w_we      = (cnt_q != 7'd0);
				w_waddr   = lcnt - 4'd1;
			end
			ST_ROUND: begin
				w_we      = 1'b1;
				w_waddr   = rnd[3:0];
				w_wdata   = sched_w;
				w_raddr0  = rnd_next[3:0];
				w_raddr1  = rnd_next[3:0] + 4'd1;
				w_raddr2  = rnd_next[3:0] + 4'd9;
				w_raddr3  = rnd_next[3:0] + 4'd14;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bit_count_q <= '0;
			fill_q      <= '0;
			cnt_q       <= '0;
			second_q    <= 1'b0;
			final_q     <= 1'b0;
			two_q       <= 1'b0;
			out_valid   <= 1'b0;
			for (int i = 0; i < HashWords; i++) begin
				hash_q[i] <= IV[i];
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (in_data.byte_present) begin
							partial_q   <= byte_word;
							bit_count_q <= bit_count_q + 64'd8;
							fill_q      <= fill_q + 6'd1;
						end
						if (in_data.byte_present && fill_q == 6'd63) begin
							state_q  <= ST_LOAD;
							cnt_q    <= '0;
							final_q  <= 1'b0;
							second_q <= 1'b0;
							two_q    <= in_data.end_of_message;
						end else if (in_data.end_of_message) begin
							state_q <= ST_PAD;
							cnt_q   <= {3'd0, fill_q[5:2] + (in_data.byte_present && lane == 2'd3
								? 4'd1 : 4'd0)};
						end
					end
				end
				ST_PAD: begin
					if (cnt_q[3:0] == 4'd15) begin
						state_q  <= (fill_q >= LenPos) ? ST_LOAD : ST_LEN;
						second_q <= (fill_q >= LenPos);
						final_q  <= (fill_q < LenPos);
						cnt_q    <= (fill_q >= LenPos) ? 7'd0 : 7'd14;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				ST_CLEAR: begin
					if (lcnt == 4'd13) begin
						state_q <= ST_LEN;
					end
					cnt_q <= cnt_q + 7'd1;
				end
				ST_LEN: begin
					if (lcnt == 4'd15) begin
						state_q <= ST_LOAD;
						final_q <= 1'b1;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				ST_LOAD: begin
					if (cnt_q == 7'd16) begin
						state_q <= ST_ROUND;
						cnt_q   <= '0;
						for (int i = 0; i < HashWords; i++) begin
							wk_q[i] <= hash_q[i];
						end
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				ST_ROUND: begin
					wk_q[7] <= wk_q[6];
					wk_q[6] <= wk_q[5];
					wk_q[5] <= wk_q[4];
					wk_q[4] <= wk_q[3] + t1;
					wk_q[3] <= wk_q[2];
					wk_q[2] <= wk_q[1];
					wk_q[1] <= wk_q[0];
					wk_q[0] <= t1 + t2;
					if (rnd == 6'd63) begin
						state_q <= ST_ADD;
					end
					cnt_q <= cnt_q + 7'd1;
				end
				ST_ADD: begin
					for (int i = 0; i < HashWords; i++) begin
						hash_q[i] <= hash_q[i] + wk_q[i];
					end
					cnt_q <= '0;
					if (final_q) begin
						state_q   <= ST_OUT;
						out_valid <= 1'b1;
					end else if (second_q) begin
						state_q  <= ST_CLEAR;
						second_q <= 1'b0;
					end else if (two_q) begin
						two_q   <= 1'b0;
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (out_fire) begin
						if (cnt_q[2:0] == 3'd7) begin
							state_q     <= ST_IDLE;
							out_valid   <= 1'b0;
							bit_count_q <= '0;
							fill_q      <= '0;
							final_q     <= 1'b0;
							for (int i = 0; i < HashWords; i++) begin
								hash_q[i] <= IV[i];
							end
						end
						cnt_q <= cnt_q + 7'd1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_data.digest_word = hash_q[cnt_q[2:0]];
	assign out_data.word_number = cnt_q[2:0];
	assign out_data.final_word  = (cnt_q[2:0] == 3'd7);

	a_out_only_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == ST_OUT)
		else $error("digest item shown outside output phase");
	a_no_in_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("input taken while digest pending");
	a_round_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND && rnd == 6'd63 |=> state_q == ST_ADD)
		else $error("compression did not end after 64 rounds");
	a_last_word_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && out_data.final_word |=> state_q == ST_IDLE)
		else $error("block not idle after last digest word");

endmodule
`default_nettype wire
